/* hw/rtl/xoo_pkg.sv */
// Shared types, round constants and the round function of the Xoodoo permutation.
package xoo_pkg;

   // Number of rounds of the full permutation and the size of the constant table.
   localparam int MAX_ROUNDS = 12;

   typedef logic [31:0] lane_type;
   typedef lane_type [3:0] plane_type;
   typedef plane_type [2:0] state_type;

   // Round constants from the first round to the last.
   localparam lane_type ROUND_CONSTS [0:MAX_ROUNDS-1] = '{
      32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
      32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
      32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
   };

   // Rotate a lane left by a fixed amount between 1 and 31.
   function automatic lane_type rotl(input lane_type v, input int unsigned n);
      lane_type r;
      r = (v << n) | (v >> (32 - n));
      return r;
   endfunction

   // One full round: theta, rho-west, iota, chi and rho-east.
   function automatic state_type xoo_round(input state_type a_in, input lane_type rc);
      state_type a;
      state_type b;
      lane_type  p [4];
      lane_type  e [4];
      a = a_in;
      // Theta: fold in the parity of the neighboring column.
      for (int x = 0; x < 4; x++) begin
         p[x] = a[0][x] ^ a[1][x] ^ a[2][x];
      end
      for (int x = 0; x < 4; x++) begin
         e[x] = rotl(p[(x + 3) % 4], 5) ^ rotl(p[(x + 3) % 4], 14);
      end
      for (int x = 0; x < 4; x++) begin
         a[0][x] = a[0][x] ^ e[x];
         a[1][x] = a[1][x] ^ e[x];
         a[2][x] = a[2][x] ^ e[x];
      end
      // Rho-west: plane 1 moves up one lane, plane 2 rotates by 11.
      b = a;
      for (int x = 0; x < 4; x++) begin
         b[1][x] = a[1][(x + 3) % 4];
         b[2][x] = rotl(a[2][x], 11);
      end
      // Iota.
      b[0][0] = b[0][0] ^ rc;
      // Chi along each column.
      for (int x = 0; x < 4; x++) begin
         a[0][x] = b[0][x] ^ (~b[1][x] & b[2][x]);
         a[1][x] = b[1][x] ^ (~b[2][x] & b[0][x]);
         a[2][x] = b[2][x] ^ (~b[0][x] & b[1][x]);
      end
      // Rho-east: plane 1 rotates by 1, plane 2 moves two lanes and rotates by 8.
      b = a;
      for (int x = 0; x < 4; x++) begin
         b[1][x] = rotl(a[1][x], 1);
         b[2][x] = rotl(a[2][(x + 2) % 4], 8);
      end
      return b;
   endfunction

endpackage

/* hw/rtl/xoodoo_384_permutation.sv */
// Top level of the pipelined Xoodoo permutation over a 384-bit state.
//
// Each transaction carries a whole Xoodoo state as six 64-bit words and comes
// back after ROUND_COUNT rounds of the permutation, using the last ROUND_COUNT
// round constants. A ROUND_COUNT above 12 is taken as 12 and one below 1 as 1.
// One register stage holds one round, and a new state can enter in every cycle
// while req_stall is low; the final stage register drives the response
// ports. A stall on the response side holds the full stages in place, and
// empty stages ahead of it still fill, so nothing is lost or repeated.
module xoodoo_384_permutation
   import xoo_pkg::*;
#(
   parameter int ROUND_COUNT = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_plane0_lanes01,
   input  logic [63:0] req_plane0_lanes23,
   input  logic [63:0] req_plane1_lanes01,
   input  logic [63:0] req_plane1_lanes23,
   input  logic [63:0] req_plane2_lanes01,
   input  logic [63:0] req_plane2_lanes23,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_plane0_lanes01,
   output logic [63:0] rsp_plane0_lanes23,
   output logic [63:0] rsp_plane1_lanes01,
   output logic [63:0] rsp_plane1_lanes23,
   output logic [63:0] rsp_plane2_lanes01,
   output logic [63:0] rsp_plane2_lanes23
);

   // Round count held to the size of the constant table.
   localparam int STAGE_COUNT = (ROUND_COUNT > MAX_ROUNDS) ? MAX_ROUNDS :
                                (ROUND_COUNT < 1) ? 1 : ROUND_COUNT;
   localparam int FIRST_ROUND = MAX_ROUNDS - STAGE_COUNT;

   state_type stage_state [0:STAGE_COUNT];
   logic      stage_valid [0:STAGE_COUNT];
   logic      stage_stall [0:STAGE_COUNT];

   // Unpack the request words into planes and lanes.
   assign stage_state[0] = {req_plane2_lanes23, req_plane2_lanes01,
                            req_plane1_lanes23, req_plane1_lanes01,
                            req_plane0_lanes23, req_plane0_lanes01};
   assign stage_valid[0] = req_valid;
   assign req_stall      = stage_stall[0];

   // Chain of round stages.
   for (genvar i = 0; i < STAGE_COUNT; i++) begin : g_round
      xoo_round_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .round_const (ROUND_CONSTS[FIRST_ROUND + i]),
         .up_valid    (stage_valid[i]),
         .up_state    (stage_state[i]),
         .up_stall    (stage_stall[i]),
         .down_valid  (stage_valid[i + 1]),
         .down_state  (stage_state[i + 1]),
         .down_stall  (stage_stall[i + 1])
      );
   end

   // The last stage register is the response.
   assign stage_stall[STAGE_COUNT] = rsp_stall;
   assign rsp_valid                = stage_valid[STAGE_COUNT];
   assign rsp_plane0_lanes01       = stage_state[STAGE_COUNT][0][1:0];
   assign rsp_plane0_lanes23       = stage_state[STAGE_COUNT][0][3:2];
   assign rsp_plane1_lanes01       = stage_state[STAGE_COUNT][1][1:0];
   assign rsp_plane1_lanes23       = stage_state[STAGE_COUNT][1][3:2];
   assign rsp_plane2_lanes01       = stage_state[STAGE_COUNT][2][1:0];
   assign rsp_plane2_lanes23       = stage_state[STAGE_COUNT][2][3:2];

endmodule

/* hw/rtl/xoo_round_stage.sv */
// One pipeline stage that applies a single Xoodoo round and registers the state.
module xoo_round_stage
   import xoo_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  lane_type  round_const,
   input  logic      up_valid,
   input  state_type up_state,
   output logic      up_stall,
   output logic      down_valid,
   output state_type down_state,
   input  logic      down_stall
);

   logic      valid_ff;
   logic      valid_in;
   state_type state_ff;
   state_type state_in;
   logic      advance;

   // The stage takes a new transaction when it is empty or its content moves on.
   assign advance  = !valid_ff || !down_stall;
   assign up_stall = !advance;
   assign valid_in = advance ? up_valid : valid_ff;
   assign state_in = xoo_round(up_state, round_const);

   // Valid bit of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // State register, loaded only when a transaction enters.
   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         state_ff <= state_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_state = state_ff;

endmodule

/* hw/rtl/xoo_checker.sv */
// Port-level checks of the Xoodoo pipeline, attached to the top level by bind.
module xoo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_plane0_lanes01,
   input logic [63:0] rsp_plane0_lanes23,
   input logic [63:0] rsp_plane1_lanes01,
   input logic [63:0] rsp_plane1_lanes23,
   input logic [63:0] rsp_plane2_lanes01,
   input logic [63:0] rsp_plane2_lanes23
);

   // A stalled response transaction stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // A stalled response transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_plane0_lanes01) && $stable(rsp_plane0_lanes23)
         && $stable(rsp_plane1_lanes01) && $stable(rsp_plane1_lanes23)
         && $stable(rsp_plane2_lanes01) && $stable(rsp_plane2_lanes23))
      else $error("response payload changed while stalled");

   // The pipeline refuses a request only when it is full behind a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while the pipeline has room");

   // Reset empties every stage, so no response follows it directly.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered right after reset");

endmodule

bind xoodoo_384_permutation xoo_checker u_xoo_checker (.*);
